// ----- rtl/lca_pkg.sv -----
// ---------------------------------------------------------------------------
// lca_pkg: shared types and constants of the label centroid accumulator
// Command codes, widths and the front/back queue entry type.
// ---------------------------------------------------------------------------
`default_nettype none
package lca_pkg;
	localparam int LABEL_BITS = 16;
	localparam int COORD_BITS = 10;
	localparam int DEPTH      = 1 << LABEL_BITS;
	localparam int SIZE_W     = 24;
	localparam int SUM_W      = 40;
	localparam int CNT_W      = 31;
	localparam int CENT_W     = 34;
	localparam int PROD_W     = SUM_W + SIZE_W;

	localparam logic [1:0] CMD_ACC    = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(1) << 30;
	localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
	localparam logic [CENT_W-1:0] CENT_MAX  = '1;

	typedef struct packed {
		logic [1:0]            cmd;
		logic [LABEL_BITS-1:0] label;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		logic [COORD_BITS-1:0] pos_z;
	} lca_item_t;

	typedef struct packed {
		logic              present;
		logic [CENT_W-1:0] centroid_x;
		logic [CENT_W-1:0] centroid_y;
		logic [CENT_W-1:0] centroid_z;
		logic [CNT_W-1:0]  voxel_count;
	} lca_result_t;
endpackage
`default_nettype wire

// ----- rtl/lca_front.sv -----
// ---------------------------------------------------------------------------
// lca_front: input decode and item queue
// Unpacks words, drops unused commands and buffers items in a short queue.
// ---------------------------------------------------------------------------
`default_nettype none
module lca_front import lca_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,
	output logic             q_valid,
	input  wire logic        q_ready,
	output lca_item_t        q_item
);
	localparam int QD = 4;
	lca_item_t        mem_q [QD];
	logic [1:0]       wp_q, rp_q;
	logic [2:0]       cnt_q;
	lca_item_t        in_item;
	logic             push, pop;

	always_comb begin
		in_item.cmd   = s_tdata[1:0];
		in_item.label = s_tdata[17:2];
		in_item.pos_x = s_tdata[27:18];
		in_item.pos_y = s_tdata[37:28];
		in_item.pos_z = s_tdata[47:38];
	end

	assign s_tready = (cnt_q != 3'(QD));
	assign push     = s_tvalid && s_tready && (in_item.cmd != CMD_UNUSED);
	assign q_valid  = (cnt_q != 3'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/lca_div.sv -----
// ---------------------------------------------------------------------------
// lca_div: iterative centroid divider
// Restoring divide of three products by the count, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module lca_div import lca_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [PROD_W-1:0] num_x,
	input  wire logic [PROD_W-1:0] num_y,
	input  wire logic [PROD_W-1:0] num_z,
	input  wire logic [CNT_W-1:0]  den,
	output logic                   done,
	output logic [CENT_W-1:0]      cx,
	output logic [CENT_W-1:0]      cy,
	output logic [CENT_W-1:0]      cz
);
	logic [PROD_W-1:0] qx_q, qy_q, qz_q;
	logic [CNT_W:0]    rx_q, ry_q, rz_q;
	logic [CNT_W-1:0]  d_q;
	logic [6:0]        n_q;
	logic              busy_q;
	logic [CNT_W:0]    tx, ty, tz;

	assign tx = {rx_q[CNT_W-1:0], qx_q[PROD_W-1]};
	assign ty = {ry_q[CNT_W-1:0], qy_q[PROD_W-1]};
	assign tz = {rz_q[CNT_W-1:0], qz_q[PROD_W-1]};

	always_ff @(posedge clk) begin
		if (start) begin
			qx_q <= num_x; qy_q <= num_y; qz_q <= num_z;
			rx_q <= '0; ry_q <= '0; rz_q <= '0;
			d_q  <= den;
		end else if (busy_q) begin
			if (tx >= {1'b0, d_q}) begin
				rx_q <= tx - {1'b0, d_q}; qx_q <= {qx_q[PROD_W-2:0], 1'b1};
			end else begin
				rx_q <= tx; qx_q <= {qx_q[PROD_W-2:0], 1'b0};
			end
			if (ty >= {1'b0, d_q}) begin
				ry_q <= ty - {1'b0, d_q}; qy_q <= {qy_q[PROD_W-2:0], 1'b1};
			end else begin
				ry_q <= ty; qy_q <= {qy_q[PROD_W-2:0], 1'b0};
			end
			if (tz >= {1'b0, d_q}) begin
				rz_q <= tz - {1'b0, d_q}; qz_q <= {qz_q[PROD_W-2:0], 1'b1};
			end else begin
				rz_q <= tz; qz_q <= {qz_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q    <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= 7'(PROD_W);
			end else if (busy_q) begin
				n_q <= n_q - 7'd1;
				if (n_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign cx = (qx_q[PROD_W-1:CENT_W] != '0) ? CENT_MAX : qx_q[CENT_W-1:0];
	assign cy = (qy_q[PROD_W-1:CENT_W] != '0) ? CENT_MAX : qy_q[CENT_W-1:0];
	assign cz = (qz_q[PROD_W-1:CENT_W] != '0) ? CENT_MAX : qz_q[CENT_W-1:0];
endmodule
`default_nettype wire

// ----- rtl/lca_back.sv -----
// ---------------------------------------------------------------------------
// lca_back: table engine
// Read-modify-write of the label table, clearing sweep and query handling.
// ---------------------------------------------------------------------------
`default_nettype none
module lca_back import lca_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	output logic                   q_ready,
	input  lca_item_t              q_item,
	input  wire logic [SIZE_W-1:0] size_x,
	input  wire logic [SIZE_W-1:0] size_y,
	input  wire logic [SIZE_W-1:0] size_z,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output lca_result_t            res,
	output logic                   sweeping
);
	localparam int ENT_W = 3 * SUM_W + CNT_W;
	localparam logic [2:0] ST_SWEEP = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DIVS  = 3'd3;
	localparam logic [2:0] ST_DIVW  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [ENT_W-1:0]      tab [DEPTH];
	logic [ENT_W-1:0]      rd_s2;
	logic [2:0]            st_q;
	logic [LABEL_BITS:0]   swp_q;
	logic                  v_s1;
	lca_item_t             it_s1;
	logic                  v_s2;
	lca_item_t             it_s2;
	logic [ENT_W-1:0]      wr_s3;
	logic                  wv_s3;
	logic [LABEL_BITS-1:0] wa_s3;
	logic [ENT_W-1:0]      ent, nent;
	logic [SUM_W-1:0]      sx, sy, sz, ax, ay, az;
	logic [CNT_W-1:0]      cn;
	logic                  wen;
	logic [LABEL_BITS-1:0] wad;
	logic [ENT_W-1:0]      wdat;
	logic [PROD_W-1:0]     px_q, py_q, pz_q;
	logic [CNT_W-1:0]      cn_q;
	logic [SUM_W-1:0]      sx_q, sy_q, sz_q;
	logic                  ddone;
	logic [CENT_W-1:0]     cx, cy, cz;
	logic                  take;
	logic                  pipe_busy;

	assign pipe_busy = v_s1 || v_s2;
	assign q_ready = (st_q == ST_RUN) && !(q_valid && q_item.cmd == CMD_QUERY && pipe_busy);
	assign take = q_valid && q_ready;
	assign sweeping = (st_q == ST_SWEEP);

	always_ff @(posedge clk) begin
		if (take) it_s1 <= q_item;
		rd_s2  <= tab[it_s1.label];
		it_s2  <= it_s1;
		if (wen) tab[wad] <= wdat;
	end

	// the read of the word behind misses the write of the same edge
	always_comb begin
		ent = (wv_s3 && wa_s3 == it_s2.label) ? wr_s3 : rd_s2;
		{sx, sy, sz, cn} = ent;
		ax = sx + SUM_W'(it_s2.pos_x);
		ay = sy + SUM_W'(it_s2.pos_y);
		az = sz + SUM_W'(it_s2.pos_z);
		if (ax < sx) ax = SUM_MAX;
		if (ay < sy) ay = SUM_MAX;
		if (az < sz) az = SUM_MAX;
		nent = ent;
		if (it_s2.cmd == CMD_CLEAR) nent = '0;
		else if (cn < COUNT_MAX) nent = {ax, ay, az, cn + CNT_W'(1)};
		wen  = sweeping || (v_s2 && it_s2.cmd != CMD_QUERY);
		wad  = sweeping ? swp_q[LABEL_BITS-1:0] : it_s2.label;
		wdat = sweeping ? '0 : nent;
	end

	always_ff @(posedge clk) begin
		wr_s3 <= wdat;
		wa_s3 <= wad;
		if (v_s2 && it_s2.cmd == CMD_QUERY && st_q == ST_RUN) begin
			sx_q <= sx; sy_q <= sy; sz_q <= sz; cn_q <= cn;
		end
		if (st_q == ST_MUL) begin
			px_q <= PROD_W'(sx_q) * PROD_W'(size_x);
			py_q <= PROD_W'(sy_q) * PROD_W'(size_y);
			pz_q <= PROD_W'(sz_q) * PROD_W'(size_z);
		end
		if (ddone) begin
			res.present     <= 1'b1;
			res.centroid_x  <= cx;
			res.centroid_y  <= cy;
			res.centroid_z  <= cz;
			res.voxel_count <= cn_q;
		end else if (st_q == ST_MUL && cn_q == '0) begin
			res <= '0;
		end
	end

	lca_div u_div (
		.clk(clk), .arst_n(arst_n), .start(st_q == ST_DIVS),
		.num_x(px_q), .num_y(py_q), .num_z(pz_q), .den(cn_q),
		.done(ddone), .cx(cx), .cy(cy), .cz(cz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_SWEEP;
			swp_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			wv_s3 <= 1'b0;
		end else begin
			v_s1  <= take;
			v_s2  <= v_s1;
			wv_s3 <= wen && !sweeping;
			unique case (st_q)
				ST_SWEEP: begin
					swp_q <= swp_q + 1'b1;
					if (swp_q == (LABEL_BITS + 1)'(DEPTH - 1)) st_q <= ST_RUN;
				end
				ST_RUN: if (v_s2 && it_s2.cmd == CMD_QUERY) st_q <= ST_MUL;
				ST_MUL: st_q <= (cn_q == '0) ? ST_OUT : ST_DIVS;
				ST_DIVS: st_q <= ST_DIVW;
				ST_DIVW: if (ddone) st_q <= ST_OUT;
				ST_OUT: if (res_ready) st_q <= ST_RUN;
				default: st_q <= ST_RUN;
			endcase
		end
	end

	assign res_valid = (st_q == ST_OUT);
endmodule
`default_nettype wire

// ----- rtl/label_centroid_accumulator_top.sv -----
// Label centroid accumulator: accumulate and clear words go in one per cycle outside
// the sweep and queries, as the label table has a single write port (3-stage
// read-modify-write). A query waits for the pipe to drain; its result then passes
// queue, table read, multiply and one-bit-a-cycle divide; an empty label skips the
// divide. A clearing pass after reset sweeps all 65536 entries; only the four-word
// input queue fills meanwhile. Config writes are always taken.
// ---------------------------------------------------------------------------
// label_centroid_accumulator_top: top level
// Config registers, front queue and table back end.
// ---------------------------------------------------------------------------
`default_nettype none
module label_centroid_accumulator_top import lca_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [47:0]  s_tdata,   // cmd, label, pos_x, pos_y, pos_z
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [135:0]      m_tdata,   // present, centroid_x/y/z, voxel_count
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [23:0]  cfg_data
);
	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic              qv, qr, swp;
	lca_item_t         qi;
	lca_result_t       res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 24'd65536;
			size_y_q <= 24'd65536;
			size_z_q <= 24'd65536;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SIZE_X) size_x_q <= cfg_data;
			if (cfg_index == REG_SIZE_Y) size_y_q <= cfg_data;
			if (cfg_index == REG_SIZE_Z) size_z_q <= cfg_data;
		end
	end

	lca_front u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .q_valid(qv), .q_ready(qr), .q_item(qi)
	);

	lca_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(qv), .q_ready(qr), .q_item(qi),
		.size_x(size_x_q), .size_y(size_y_q), .size_z(size_z_q),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(res), .sweeping(swp)
	);

	assign m_tdata = {2'b00, res.voxel_count, res.centroid_z, res.centroid_y,
		res.centroid_x, res.present};

	a_sweep_idle: assert property (@(posedge clk) disable iff (!arst_n)
		swp |-> !m_tvalid) else $error("result during sweep");
	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.present |-> res.voxel_count == '0)
		else $error("absent label with count");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
endmodule
`default_nettype wire

// ----- tb/sv/label_centroid_accumulator_top_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// label_centroid_accumulator_top_test: self-checking testbench
// Drives labelled voxel, query, clear and unused-command words through the
// stream input and predicts each query result from a shadow label table.
// Results are checked in order against the predictions. Voxel size registers are
// rewritten between phases, extremes included. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module label_centroid_accumulator_top_test;
	import lca_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [47:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [23:0]  cfg_data = '0;

	label_centroid_accumulator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow label table and voxel sizes
	logic [SUM_W-1:0]  shadow_sx [int];
	logic [SUM_W-1:0]  shadow_sy [int];
	logic [SUM_W-1:0]  shadow_sz [int];
	logic [CNT_W-1:0]  shadow_cnt [int];
	logic [SIZE_W-1:0] size_x = 24'd65536;
	logic [SIZE_W-1:0] size_y = 24'd65536;
	logic [SIZE_W-1:0] size_z = 24'd65536;

	lca_item_t   words_to_send [$];
	lca_result_t centroids_due [$];
	logic        s_took = 1'b0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          mismatches = 0;
	int          n_acc = 0, n_query = 0, n_clear = 0, n_unused = 0, n_cfg = 0;

	function automatic logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] s,
			logic [COORD_BITS-1:0] v);
		logic [SUM_W:0] r;
		r = {1'b0, s} + v;
		return r[SUM_W] ? SUM_MAX : r[SUM_W-1:0];
	endfunction

	function automatic logic [CENT_W-1:0] axis_centroid(logic [SUM_W-1:0] s,
			logic [SIZE_W-1:0] sz, logic [CNT_W-1:0] n);
		logic [63:0] q;
		q = (64'(s) * 64'(sz)) / 64'(n);
		return (q > 64'(CENT_MAX)) ? CENT_MAX : q[CENT_W-1:0];
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// apply an accepted word to the shadow table
	task automatic take_word(lca_item_t w);
		int l;
		lca_result_t r;
		l = w.label;
		if (!shadow_cnt.exists(l)) begin
			shadow_sx[l] = '0; shadow_sy[l] = '0; shadow_sz[l] = '0; shadow_cnt[l] = '0;
		end
		case (w.cmd)
			CMD_ACC: begin
				n_acc++;
				if (shadow_cnt[l] < COUNT_MAX) begin
					shadow_sx[l] = sum_sat(shadow_sx[l], w.pos_x);
					shadow_sy[l] = sum_sat(shadow_sy[l], w.pos_y);
					shadow_sz[l] = sum_sat(shadow_sz[l], w.pos_z);
					shadow_cnt[l] = shadow_cnt[l] + 1'b1;
				end
			end
			CMD_CLEAR: begin
				n_clear++;
				shadow_sx[l] = '0; shadow_sy[l] = '0; shadow_sz[l] = '0; shadow_cnt[l] = '0;
			end
			CMD_QUERY: begin
				n_query++;
				r = '0;
				if (shadow_cnt[l] != 0) begin
					r.present = 1'b1;
					r.centroid_x = axis_centroid(shadow_sx[l], size_x, shadow_cnt[l]);
					r.centroid_y = axis_centroid(shadow_sy[l], size_y, shadow_cnt[l]);
					r.centroid_z = axis_centroid(shadow_sz[l], size_z, shadow_cnt[l]);
					r.voxel_count = shadow_cnt[l];
				end
				centroids_due.push_back(r);
			end
			default: n_unused++;
		endcase
	endtask

	// input acceptance and result checking at the rising edge
	always @(posedge clk) begin
		lca_item_t w;
		lca_result_t got, want;
		s_took <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			w = '{cmd: s_tdata[1:0], label: s_tdata[17:2], pos_x: s_tdata[27:18],
				pos_y: s_tdata[37:28], pos_z: s_tdata[47:38]};
			take_word(w);
		end
		if (m_tvalid && m_tready) begin
			got = '{present: m_tdata[0], centroid_x: m_tdata[34:1],
				centroid_y: m_tdata[68:35], centroid_z: m_tdata[102:69],
				voxel_count: m_tdata[133:103]};
			if (centroids_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", got);
			end else begin
				want = centroids_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp p=%0d x=%h y=%h z=%h n=%0d, got p=%0d x=%h y=%h z=%h n=%0d",
							want.present, want.centroid_x, want.centroid_y, want.centroid_z,
							want.voxel_count, got.present, got.centroid_x, got.centroid_y,
							got.centroid_z, got.voxel_count);
				end
			end
		end
	end

	// stream driver and result-side stalls
	always @(negedge clk) begin
		lca_item_t w;
		if (!s_tvalid || s_took) begin
			if (s_tvalid)
				gap_left = gap_len();
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (words_to_send.size() > 0) begin
				w = words_to_send.pop_front();
				s_tdata <= {w.pos_z, w.pos_y, w.pos_x, w.label, w.cmd};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			stall_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			m_tready <= (stall_left == 0);
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_SIZE_X: size_x = val;
			REG_SIZE_Y: size_y = val;
			REG_SIZE_Z: size_z = val;
			default: ;
		endcase
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_word(logic [1:0] c, logic [15:0] l, logic [9:0] x,
			logic [9:0] y, logic [9:0] z);
		words_to_send.push_back('{cmd: c, label: l, pos_x: x, pos_y: y, pos_z: z});
	endtask

	task automatic drain();
		@(posedge clk);
		while (words_to_send.size() > 0 || s_tvalid || centroids_due.size() > 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		logic [15:0] pool [8];
		logic [1:0] c;
		logic [15:0] l;
		int r;
		pool[0] = 16'h0000;
		pool[1] = 16'hFFFF;
		for (int i = 2; i < 8; i++) pool[i] = 16'($urandom);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			c = (r < 60) ? CMD_ACC : (r < 87) ? CMD_QUERY : (r < 96) ? CMD_CLEAR : CMD_UNUSED;
			l = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 7)] : 16'($urandom);
			r = $urandom_range(0, 9);
			if (r == 0)
				push_word(c, l, 10'h3FF, 10'h3FF, 10'h3FF);
			else if (r == 1)
				push_word(c, l, 10'h000, 10'h000, 10'h000);
			else
				push_word(c, l, 10'($urandom), 10'($urandom), 10'($urandom));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: absent label, coordinate extremes, clear, unused command
		write_reg(REG_SIZE_X, 24'd65536);
		write_reg(REG_SIZE_Y, 24'd65536);
		write_reg(REG_SIZE_Z, 24'd65536);
		push_word(CMD_QUERY, 16'h0000, 10'd0, 10'd0, 10'd0);
		push_word(CMD_ACC,   16'h0000, 10'd0, 10'd0, 10'd0);
		push_word(CMD_ACC,   16'h0000, 10'h3FF, 10'h3FF, 10'h3FF);
		push_word(CMD_QUERY, 16'h0000, 10'd0, 10'd0, 10'd0);
		push_word(CMD_ACC,   16'hFFFF, 10'h3FF, 10'h000, 10'h155);
		push_word(CMD_ACC,   16'hFFFF, 10'h000, 10'h3FF, 10'h2AA);
		push_word(CMD_ACC,   16'hFFFF, 10'h001, 10'h002, 10'h003);
		push_word(CMD_QUERY, 16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF);
		push_word(CMD_CLEAR, 16'h0000, 10'h3FF, 10'h3FF, 10'h3FF);
		push_word(CMD_QUERY, 16'h0000, 10'd0, 10'd0, 10'd0);
		push_word(CMD_UNUSED, 16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF);
		push_word(CMD_QUERY, 16'hFFFF, 10'd0, 10'd0, 10'd0);
		push_word(CMD_CLEAR, 16'h1234, 10'd0, 10'd0, 10'd0);
		push_word(CMD_QUERY, 16'h1234, 10'd0, 10'd0, 10'd0);
		drain();

		// maximum voxel size, plus a write to the unused index
		write_reg(REG_SIZE_X, 24'hFFFFFF);
		write_reg(REG_SIZE_Y, 24'hFFFFFF);
		write_reg(REG_SIZE_Z, 24'hFFFFFF);
		write_reg(REG_UNUSED, 24'h5A5A5A);
		push_word(CMD_QUERY, 16'hFFFF, 10'd0, 10'd0, 10'd0);
		random_phase(425);
		drain();

		write_reg(REG_SIZE_X, 24'd0);
		write_reg(REG_SIZE_Y, 24'd0);
		write_reg(REG_SIZE_Z, 24'd0);
		random_phase(425);
		drain();

		write_reg(REG_SIZE_X, 24'($urandom));
		write_reg(REG_SIZE_Y, 24'($urandom));
		write_reg(REG_SIZE_Z, 24'($urandom));
		random_phase(425);
		drain();

		write_reg(REG_SIZE_X, 24'h000001);
		write_reg(REG_SIZE_Y, 24'h800000);
		write_reg(REG_SIZE_Z, 24'h018000);
		random_phase(425);
		drain();

		$display("covered %0d voxels, %0d queries, %0d clears, %0d unused words",
			n_acc, n_query, n_clear, n_unused);
		$display("%0d register writes over five voxel size settings", n_cfg);
		if (mismatches == 0)
			$display("label_centroid_accumulator_top_test OK");
		else
			$display("label_centroid_accumulator_top_test NOT OK");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("label_centroid_accumulator_top_test NOT OK");
		$finish;
	end
endmodule

// ----- label_centroid_accumulator_top.f -----
rtl/lca_pkg.sv
rtl/lca_front.sv
rtl/lca_div.sv
rtl/lca_back.sv
rtl/label_centroid_accumulator_top.sv
tb/sv/label_centroid_accumulator_top_test.sv
